// ===== hdl/fractal_escape_time_iterator_assert.svh =====
// Assertion macros for the escape-time iterator checks
`ifndef FRACTAL_ESCAPE_TIME_ITERATOR_ASSERT_SVH
`define FRACTAL_ESCAPE_TIME_ITERATOR_ASSERT_SVH

// implication checked in the next cycle, quiet during reset
`define FEI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// same-cycle implication, quiet during reset
`define FEI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// implication checked in the next cycle, also across reset
`define FEI_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/fei_pkg.sv =====
// Shared types, constants and helpers of the escape-time iterator
`timescale 1ns / 1ps
package fei_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_CAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT  = 1'd1;

  localparam logic [15:0] ITER_CAP_RESET = 16'd50;
  localparam logic        VARIANT_RESET  = 1'b0;
  localparam logic        VARIANT_STD    = 1'b0;
  localparam logic        VARIANT_SHIP   = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] start_re;
    logic signed [31:0] start_im;
    logic signed [31:0] const_re;
    logic signed [31:0] const_im;
    logic [15:0]        iter_cap;
    logic               variant;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [63:0] mag;
  } rs_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } rs_rsp_t;

  function automatic logic signed [31:0] sat_abs(input logic signed [65:0] v,
                                                 input logic do_abs);
    logic signed [65:0] a;
    a = (do_abs && v < 0) ? -v : v;
    if (a > 66'(S32_MAX)) return S32_MAX;
    if (a < 66'(S32_MIN)) return S32_MIN;
    return a[31:0];
  endfunction

endpackage

// ===== hdl/fei_front.sv =====
// Input stage: configuration registers and capture of incoming beats
`timescale 1ns / 1ps
module fei_front import fei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_start_re,
  input  logic signed [31:0]    in_start_im,
  input  logic signed [31:0]    in_const_re,
  input  logic signed [31:0]    in_const_im,
  output logic                  push,
  output job_t                  push_job,
  input  logic                  q_full
);

  logic [15:0] iter_cap_r;
  logic        variant_r;
  logic        hold_v_r;
  job_t        hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_cap_r <= ITER_CAP_RESET;
      variant_r  <= VARIANT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ITER_CAP: iter_cap_r <= cfg_data;
        REG_VARIANT:  variant_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign push     = hold_v_r && !q_full;
  assign in_stall = hold_v_r && q_full;
  assign push_job = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_v_r <= 1'b1;
    end else if (push) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_r.start_re <= in_start_re;
      hold_r.start_im <= in_start_im;
      hold_r.const_re <= in_const_re;
      hold_r.const_im <= in_const_im;
      hold_r.iter_cap <= iter_cap_r;
      hold_r.variant  <= variant_r;
    end
  end

endmodule

// ===== hdl/fei_queue.sv =====
// Short job queue between the input stage and the iteration engine
`timescale 1ns / 1ps
module fei_queue import fei_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [PW:0]   cnt_r;

  assign full    = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

endmodule

// ===== hdl/fei_rsqrt.sv =====
// Serial reciprocal square root: long division then digit-by-digit root
`timescale 1ns / 1ps
module fei_rsqrt import fei_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic    clk,
  input  logic    rst_n,
  input  rs_req_t req,
  output rs_rsp_t rsp
);

  localparam int TW    = 33 + FRAC_BITS;
  localparam int T_BIT = 32 + FRAC_BITS;
  localparam int CW    = $clog2(TW);

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_DIV  = 2'd1;
  localparam logic [1:0] RS_ROOT = 2'd2;

  logic [1:0]  state_r;
  logic [CW-1:0] cnt_r;
  logic [63:0] m_r, rem_r, q_r, x_r, res_r, bit_r;
  logic        ovf_r;
  logic        done_r;
  logic [31:0] root_r;

  logic [64:0] rem_sh;
  logic        qbit;
  logic [63:0] rem_nxt, q_nxt;
  logic        ovf_nxt;
  logic [63:0] sum_w, x_nxt, res_nxt;
  logic        ge_w;

  always_comb begin
    rem_sh  = {rem_r, (cnt_r == CW'(T_BIT))};
    qbit    = (rem_sh >= {1'b0, m_r});
    rem_nxt = qbit ? 64'(rem_sh - {1'b0, m_r}) : rem_sh[63:0];
    q_nxt   = {q_r[62:0], qbit};
    ovf_nxt = ovf_r | q_r[63];
    sum_w   = res_r + bit_r;
    ge_w    = (x_r >= sum_w);
    x_nxt   = ge_w ? x_r - sum_w : x_r;
    res_nxt = ge_w ? (res_r >> 1) + bit_r : res_r >> 1;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        RS_IDLE: begin
          if (req.start) state_r <= RS_DIV;
        end
        RS_DIV: begin
          if (cnt_r == '0) state_r <= RS_ROOT;
        end
        RS_ROOT: begin
          if (bit_r[0]) begin
            state_r <= RS_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= RS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      RS_IDLE: begin
        m_r   <= req.mag;
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        cnt_r <= CW'(TW - 1);
      end
      RS_DIV: begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        ovf_r <= ovf_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          x_r   <= ovf_nxt ? '1 : q_nxt;
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      RS_ROOT: begin
        x_r    <= x_nxt;
        res_r  <= res_nxt;
        bit_r  <= bit_r >> 2;
        root_r <= res_nxt[31:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/fei_engine.sv =====
// Iteration engine: complex map steps, escape test and colour value
`timescale 1ns / 1ps
module fei_engine import fei_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  job_t               q_job,
  output logic               pop,
  output rs_req_t            rs_req,
  input  rs_rsp_t            rs_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_iteration_count,
  output logic               out_escaped,
  output logic signed [31:0] out_smooth_colour
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [63:0] LIM = 64'd4 << FRAC_BITS;

  logic [2:0]         state_r;
  logic signed [31:0] zr_r, zi_r, cr_r, ci_r;
  logic [15:0]        max_r, i_r;
  logic               variant_r;
  logic signed [63:0] prr_r, pii_r, pri_r;
  logic [63:0]        m_r;
  logic               start_rs_r;
  logic [15:0]        cnt_out_r;
  logic               esc_r;
  logic signed [31:0] col_r;

  logic signed [63:0] sr_w, si_w, cross_w;
  logic [63:0]        m_new;
  logic signed [65:0] nre_w, nim_w;
  logic               at_limit, stop_w;
  logic [63:0]        m_nxt;
  logic signed [33:0] col_w;

  always_comb begin
    sr_w     = prr_r >>> FRAC_BITS;
    si_w     = pii_r >>> FRAC_BITS;
    cross_w  = pri_r >>> (FRAC_BITS - 1);
    m_new    = sr_w + si_w;
    nre_w    = 66'(sr_w) - 66'(si_w) + 66'(cr_r);
    nim_w    = 66'(cross_w) + 66'(ci_r);
    at_limit = (i_r >= max_r);
    if (variant_r == VARIANT_STD) begin
      stop_w = at_limit || (m_new > LIM);
      m_nxt  = (at_limit && i_r != '0) ? m_r : m_new;
    end else begin
      stop_w = at_limit || (m_new >= LIM);
      m_nxt  = m_new;
    end
    col_w = $signed({1'b0, 17'(i_r) + 17'd1, 16'd0}) - $signed({2'b00, rs_rsp.root});
  end

  assign pop                 = (state_r == ST_IDLE) && !q_empty;
  assign rs_req.start        = start_rs_r;
  assign rs_req.mag          = m_r;
  assign out_valid           = (state_r == ST_DONE);
  assign out_iteration_count = cnt_out_r;
  assign out_escaped         = esc_r;
  assign out_smooth_colour   = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      start_rs_r <= 1'b0;
    end else begin
      start_rs_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) state_r <= ST_MUL;
        end
        ST_MUL: state_r <= ST_EVAL;
        ST_EVAL: begin
          if (!stop_w) begin
            state_r <= ST_MUL;
          end else if (m_nxt == '0) begin
            state_r <= ST_DONE;
          end else begin
            state_r    <= ST_ROOT;
            start_rs_r <= 1'b1;
          end
        end
        ST_ROOT: begin
          if (rs_rsp.done) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_stall) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        zr_r      <= q_job.start_re;
        zi_r      <= q_job.start_im;
        cr_r      <= q_job.const_re;
        ci_r      <= q_job.const_im;
        max_r     <= q_job.iter_cap;
        variant_r <= q_job.variant;
        i_r       <= '0;
      end
      ST_MUL: begin
        prr_r <= zr_r * zr_r;
        pii_r <= zi_r * zi_r;
        pri_r <= zr_r * zi_r;
      end
      ST_EVAL: begin
        m_r <= m_nxt;
        if (!stop_w) begin
          zr_r <= sat_abs(nre_w, variant_r);
          zi_r <= sat_abs(nim_w, variant_r);
          i_r  <= i_r + 1'b1;
        end else begin
          cnt_out_r <= i_r;
          esc_r     <= (i_r < max_r);
          col_r     <= S32_MIN;
        end
      end
      ST_ROOT: begin
        if (rs_rsp.done) col_r <= sat_abs(66'(col_w), 1'b0);
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/fractal_escape_time_iterator.sv =====
// Top level of the escape-time iterator
// Each map step of a pixel passes through a multiply state and an evaluate state;
// after the last step the reciprocal square root runs (serial division of
// 33 + COORD_FRAC_BITS quotient bits, then 32 root digits) unless the final
// squared magnitude is zero. The engine handles one pixel at a time; an input
// register and a two-entry queue keep taking beats while it works and while a
// result waits on out_stall, until both are full.
`timescale 1ns / 1ps
module fractal_escape_time_iterator import fei_pkg::*; #(
  parameter int COORD_FRAC_BITS = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_start_re,
  input  logic signed [31:0]    in_start_im,
  input  logic signed [31:0]    in_const_re,
  input  logic signed [31:0]    in_const_im,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_iteration_count,
  output logic                  out_escaped,
  output logic signed [31:0]    out_smooth_colour
);

  logic    push, q_full, q_empty, pop;
  job_t    push_job, pop_job;
  rs_req_t rs_req;
  rs_rsp_t rs_rsp;

  fei_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_start_re, .in_start_im, .in_const_re, .in_const_im,
    .push, .push_job, .q_full
  );

  fei_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full),
    .pop, .empty(q_empty), .pop_job
  );

  fei_rsqrt #(.FRAC_BITS(COORD_FRAC_BITS)) u_rsqrt (
    .clk, .rst_n, .req(rs_req), .rsp(rs_rsp)
  );

  fei_engine #(.FRAC_BITS(COORD_FRAC_BITS)) u_engine (
    .clk, .rst_n, .q_empty, .q_job(pop_job), .pop, .rs_req, .rs_rsp,
    .out_valid, .out_stall, .out_iteration_count, .out_escaped, .out_smooth_colour
  );

endmodule

// ===== hdl/fei_checker.sv =====
// Port-level checks of the escape-time iterator, bound to the top level
`timescale 1ns / 1ps
`include "fractal_escape_time_iterator_assert.svh"
module fei_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_iteration_count,
  input logic        out_escaped,
  input logic [31:0] out_smooth_colour
);

  `FEI_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && !in_stall)
  `FEI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `FEI_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_smooth_colour))
  `FEI_ASSERT_NOW(a_full_count, out_valid && out_iteration_count == 16'hFFFF, !out_escaped)

endmodule

bind fractal_escape_time_iterator fei_checker u_fei_checker (.*);
